// ===== src/beam_drag_force_relax_unit_assert.svh =====
// Assertion macros for the beam drag force unit.
`ifndef BEAM_DRAG_FORCE_RELAX_UNIT_ASSERT_SVH
`define BEAM_DRAG_FORCE_RELAX_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define BDFR_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define BDFR_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/bdfr_pkg.sv =====
// Types and constants of the beam drag force unit.
package bdfr_pkg;

	localparam int unsigned NumAxes = 3;
	localparam int unsigned SqrtSteps = 32;
	localparam int unsigned DivSteps = 29;
	localparam int unsigned UnitFrac = 28;
	localparam int unsigned KSplit = 25;

	localparam logic [16:0] WeightOne = 17'h10000;
	localparam logic [50:0] TermCap = 51'd1 << 50;

	typedef enum logic [1:0] {
		CFG_COEFF_NORMAL  = 2'd0,
		CFG_COEFF_TANGENT = 2'd1,
		CFG_RELAX_WEIGHT  = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic signed [31:0] fluid_vel_x;
		logic signed [31:0] fluid_vel_y;
		logic signed [31:0] fluid_vel_z;
		logic signed [31:0] beam_vel_x;
		logic signed [31:0] beam_vel_y;
		logic signed [31:0] beam_vel_z;
		logic signed [31:0] tangent_x;
		logic signed [31:0] tangent_y;
		logic signed [31:0] tangent_z;
		logic signed [31:0] prev_force_x;
		logic signed [31:0] prev_force_y;
		logic signed [31:0] prev_force_z;
	} cell_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic               saturated;
	} drag_t;

endpackage

// ===== src/beam_drag_force_relax_unit.sv =====
// Throughput: one cell per cycle while the output is not stalled; two 32-step square roots
// and a 29-step divider are fully pipelined, one iteration per stage.
// A stalled output result holds the whole pipeline, and the input stalls with it.
// Reset clears all valid bits and loads coefficients 0 and relaxation weight 1.0.
`include "beam_drag_force_relax_unit_assert.svh"

module beam_drag_force_relax_unit
	import bdfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        cell_valid,
	output logic        cell_stall,
	input  cell_t       cell_data,
	output logic        drag_valid,
	input  logic        drag_stall,
	output drag_t       drag
);

	localparam logic [28:0] QuotMax = 29'd1 << UnitFrac;
	localparam logic signed [69:0] OutMax = 70'sd2147483647;
	localparam logic signed [69:0] OutMin = -70'sd2147483648;

	function automatic logic [4:0] norm_shift(input logic [30:0] m);
		logic [4:0] n;
		n = 5'd0;
		for (int b = 0; b <= 30; b++) begin
			if (m[b]) n = 5'(30 - b);
		end
		return n;
	endfunction

	function automatic logic [31:0] tnabs_root(input logic signed [32:0] v);
		return 32'(v[32] ? -v : v);
	endfunction

	logic        advance;
	logic [31:0] coeff_normal_q, coeff_tangent_q;
	logic [16:0] relax_weight_q;

	assign advance = !(drag_valid && drag_stall);
	assign cell_stall = !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_normal_q <= '0;
			coeff_tangent_q <= '0;
			relax_weight_q <= WeightOne;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COEFF_NORMAL: coeff_normal_q <= cfg_data;
				CFG_COEFF_TANGENT: coeff_tangent_q <= cfg_data;
				CFG_RELAX_WEIGHT: relax_weight_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// Front end: relative velocity, tangent normalization and squares.
	logic signed [31:0] fl [NumAxes], bm [NumAxes], tg [NumAxes], pv [NumAxes];

	always_comb begin
		fl[0] = cell_data.fluid_vel_x;
		fl[1] = cell_data.fluid_vel_y;
		fl[2] = cell_data.fluid_vel_z;
		bm[0] = cell_data.beam_vel_x;
		bm[1] = cell_data.beam_vel_y;
		bm[2] = cell_data.beam_vel_z;
		tg[0] = cell_data.tangent_x;
		tg[1] = cell_data.tangent_y;
		tg[2] = cell_data.tangent_z;
		pv[0] = cell_data.prev_force_x;
		pv[1] = cell_data.prev_force_y;
		pv[2] = cell_data.prev_force_z;
	end

	logic               v_s1, v_s2, v_s3;
	logic signed [33:0] r_s1 [NumAxes], r_s2 [NumAxes], r_s3 [NumAxes];
	logic signed [31:0] t_s1 [NumAxes];
	logic signed [31:0] p_s1 [NumAxes], p_s2 [NumAxes], p_s3 [NumAxes];
	logic signed [32:0] tn_s2 [NumAxes], tn_s3 [NumAxes];
	logic               tz_s2, tz_s3;
	logic [61:0]        rsq_s2 [NumAxes];
	logic [63:0]        tsq_s3 [NumAxes];
	logic [63:0]        vsq_s3;

	logic [31:0]        tabs [NumAxes], rabs [NumAxes], tnabs [NumAxes];
	logic [31:0]        tmax;
	logic [4:0]         nshift;
	logic signed [32:0] tn [NumAxes];

	always_comb begin
		tmax = '0;
		for (int i = 0; i < NumAxes; i++) begin
			tabs[i] = 32'(t_s1[i][31] ? -33'(t_s1[i]) : 33'(t_s1[i]));
			rabs[i] = 32'(r_s1[i][33] ? -r_s1[i] : r_s1[i]);
			if (tabs[i] > tmax) tmax = tabs[i];
		end
		// Bring the largest component up to bit 30 or 31.
		nshift = norm_shift(tmax[30:0]);
		for (int i = 0; i < NumAxes; i++) begin
			tn[i] = 33'(t_s1[i]) <<< nshift;
			tnabs[i] = 32'(tn_s2[i][32] ? -tn_s2[i] : tn_s2[i]);
		end
	end

	// Root pipeline: index 0 holds the sums, index k the state after k iterations.
	logic               root_v_s [SqrtSteps+1];
	logic [63:0]        root_tx_s [SqrtSteps+1], root_tres_s [SqrtSteps+1];
	logic [63:0]        root_vx_s [SqrtSteps+1], root_vres_s [SqrtSteps+1];
	logic signed [33:0] root_r_s [SqrtSteps+1][NumAxes];
	logic signed [31:0] root_p_s [SqrtSteps+1][NumAxes];
	logic signed [32:0] root_tn_s [SqrtSteps+1][NumAxes];
	logic               root_tz_s [SqrtSteps+1];

	// Divider pipeline: index 0 holds the setup, index j the state after j steps.
	logic               div_v_s [DivSteps+1];
	logic [59:0]        div_rem_s [DivSteps+1][NumAxes];
	logic [28:0]        div_q_s [DivSteps+1][NumAxes];
	logic               div_neg_s [DivSteps+1][NumAxes];
	logic [31:0]        div_tl_s [DivSteps+1];
	logic [48:0]        div_kn_s [DivSteps+1], div_kt_s [DivSteps+1];
	logic signed [33:0] div_r_s [DivSteps+1][NumAxes];
	logic signed [31:0] div_p_s [DivSteps+1][NumAxes];
	logic               div_tz_s [DivSteps+1];

	logic [32:0] vmag;
	assign vmag = {root_vres_s[SqrtSteps][31:0], 1'b0};

	// Back end registers.
	logic               v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	logic signed [29:0] u_s4 [NumAxes], u_s5 [NumAxes], u_s6 [NumAxes];
	logic signed [33:0] r_s4 [NumAxes], r_s5 [NumAxes], r_s6 [NumAxes], r_s7 [NumAxes];
	logic signed [31:0] p_s4 [NumAxes], p_s5 [NumAxes], p_s6 [NumAxes], p_s7 [NumAxes];
	logic signed [31:0] p_s8 [NumAxes], p_s9 [NumAxes], p_s10 [NumAxes], p_s11 [NumAxes];
	logic [48:0]        kn_s4, kn_s5, kn_s6, kn_s7, kn_s8;
	logic [48:0]        kt_s4, kt_s5, kt_s6, kt_s7, kt_s8;
	logic               tz_s4, tz_s5, tz_s6, tz_s7, tz_s8;
	logic signed [63:0] pr_s5 [NumAxes];
	logic signed [35:0] dot_s6;
	logic signed [65:0] pu_s7 [NumAxes];
	logic [34:0]        magn_s8 [NumAxes], magt_s8 [NumAxes];
	logic               negn_s8 [NumAxes], negt_s8 [NumAxes];
	logic               negn_s9 [NumAxes], negt_s9 [NumAxes];
	logic [59:0]        pnl_s9 [NumAxes], ptl_s9 [NumAxes];
	logic [58:0]        pnh_s9 [NumAxes], pth_s9 [NumAxes];
	logic signed [51:0] termn_s10 [NumAxes], termt_s10 [NumAxes];
	logic               sat_s10, sat_s11, sat_s12;
	logic signed [51:0] f_s11 [NumAxes];
	logic signed [69:0] fw_s12 [NumAxes];
	logic signed [49:0] pw_s12 [NumAxes];
	drag_t              drag_s13;

	// Combinational pieces of the back end.
	logic signed [63:0] dot_sum;
	logic signed [35:0] ut [NumAxes], un [NumAxes];
	logic [83:0]        prod_n [NumAxes], prod_t [NumAxes];
	logic [67:0]        mn [NumAxes], mt [NumAxes];
	logic [50:0]        mnc [NumAxes], mtc [NumAxes];
	logic               term_sat;
	logic signed [52:0] fsum [NumAxes];
	logic signed [51:0] fcl [NumAxes];
	logic               f_sat;
	logic [16:0]        w;
	logic signed [69:0] bl_sum [NumAxes], bl_sh [NumAxes];
	logic signed [31:0] fo [NumAxes];
	logic               o_sat;

	always_comb begin
		dot_sum = pr_s5[0] + pr_s5[1] + pr_s5[2];
		term_sat = 1'b0;
		f_sat = 1'b0;
		o_sat = 1'b0;
		w = (relax_weight_q > WeightOne) ? WeightOne : relax_weight_q;
		for (int i = 0; i < NumAxes; i++) begin
			ut[i] = 36'(pu_s7[i] >>> UnitFrac);
			un[i] = 36'(r_s7[i]) - ut[i];

			prod_n[i] = 84'(pnl_s9[i]) + (84'(pnh_s9[i]) << KSplit);
			prod_t[i] = 84'(ptl_s9[i]) + (84'(pth_s9[i]) << KSplit);
			mn[i] = prod_n[i][83:16];
			mt[i] = prod_t[i][83:16];
			mnc[i] = mn[i][50:0];
			mtc[i] = mt[i][50:0];
			if (mn[i] > 68'(TermCap)) begin
				mnc[i] = TermCap;
				term_sat = 1'b1;
			end
			if (mt[i] > 68'(TermCap)) begin
				mtc[i] = TermCap;
				term_sat = 1'b1;
			end

			fsum[i] = 53'(termn_s10[i]) + 53'(termt_s10[i]);
			fcl[i] = 52'(fsum[i]);
			if (fsum[i] > $signed(53'(TermCap))) begin
				fcl[i] = 52'($signed(53'(TermCap)));
				f_sat = 1'b1;
			end else if (fsum[i] < -$signed(53'(TermCap))) begin
				fcl[i] = 52'(-$signed(53'(TermCap)));
				f_sat = 1'b1;
			end

			bl_sum[i] = fw_s12[i] + 70'(pw_s12[i]);
			bl_sh[i] = bl_sum[i] >>> 16;
			fo[i] = 32'(bl_sh[i]);
			if (bl_sh[i] > OutMax) begin
				fo[i] = 32'(OutMax);
				o_sat = 1'b1;
			end else if (bl_sh[i] < OutMin) begin
				fo[i] = 32'(OutMin);
				o_sat = 1'b1;
			end
		end
	end

	// Valid bits of the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			root_v_s[0] <= 1'b0;
			div_v_s[0] <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (advance) begin
			v_s1 <= cell_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			root_v_s[0] <= v_s3;
			div_v_s[0] <= root_v_s[SqrtSteps];
			v_s4 <= div_v_s[DivSteps];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	// Data of the fixed stages.
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < NumAxes; i++) begin
				r_s1[i] <= 34'(fl[i]) - 34'(bm[i]);
				t_s1[i] <= tg[i];
				p_s1[i] <= pv[i];

				r_s2[i] <= r_s1[i];
				p_s2[i] <= p_s1[i];
				tn_s2[i] <= tn[i];
				rsq_s2[i] <= 62'((64'(rabs[i]) * 64'(rabs[i])) >> 2);

				r_s3[i] <= r_s2[i];
				p_s3[i] <= p_s2[i];
				tn_s3[i] <= tn_s2[i];
				tsq_s3[i] <= 64'(tnabs[i]) * 64'(tnabs[i]);

				root_r_s[0][i] <= r_s3[i];
				root_p_s[0][i] <= p_s3[i];
				root_tn_s[0][i] <= tn_s3[i];

				div_rem_s[0][i] <= 60'(tnabs_root(root_tn_s[SqrtSteps][i])) << UnitFrac;
				div_q_s[0][i] <= '0;
				div_neg_s[0][i] <= root_tn_s[SqrtSteps][i][32];
				div_r_s[0][i] <= root_r_s[SqrtSteps][i];
				div_p_s[0][i] <= root_p_s[SqrtSteps][i];

				// A zero tangent leaves the divider output meaningless; force the unit vector to zero.
				if (div_tz_s[DivSteps]) begin
					u_s4[i] <= '0;
				end else begin
					u_s4[i] <= div_neg_s[DivSteps][i] ? -30'(div_q_s[DivSteps][i])
					                                  : 30'(div_q_s[DivSteps][i]);
				end
				r_s4[i] <= div_r_s[DivSteps][i];
				p_s4[i] <= div_p_s[DivSteps][i];

				pr_s5[i] <= 64'(r_s4[i]) * 64'(u_s4[i]);
				u_s5[i] <= u_s4[i];
				r_s5[i] <= r_s4[i];
				p_s5[i] <= p_s4[i];

				u_s6[i] <= u_s5[i];
				r_s6[i] <= r_s5[i];
				p_s6[i] <= p_s5[i];

				pu_s7[i] <= 66'(dot_s6) * 66'(u_s6[i]);
				r_s7[i] <= r_s6[i];
				p_s7[i] <= p_s6[i];

				magn_s8[i] <= 35'(un[i][35] ? -un[i] : un[i]);
				magt_s8[i] <= 35'(ut[i][35] ? -ut[i] : ut[i]);
				negn_s8[i] <= un[i][35];
				negt_s8[i] <= ut[i][35];
				p_s8[i] <= p_s7[i];

				pnl_s9[i] <= 60'(kn_s8[KSplit-1:0]) * 60'(magn_s8[i]);
				pnh_s9[i] <= 59'(kn_s8[48:KSplit]) * 59'(magn_s8[i]);
				ptl_s9[i] <= 60'(kt_s8[KSplit-1:0]) * 60'(magt_s8[i]);
				pth_s9[i] <= 59'(kt_s8[48:KSplit]) * 59'(magt_s8[i]);
				negn_s9[i] <= negn_s8[i];
				negt_s9[i] <= negt_s8[i];
				p_s9[i] <= p_s8[i];

				// Drag opposes the motion of its part.
				termn_s10[i] <= negn_s9[i] ? $signed({1'b0, mnc[i]}) : -$signed({1'b0, mnc[i]});
				termt_s10[i] <= negt_s9[i] ? $signed({1'b0, mtc[i]}) : -$signed({1'b0, mtc[i]});
				p_s10[i] <= p_s9[i];

				f_s11[i] <= fcl[i];
				p_s11[i] <= p_s10[i];

				fw_s12[i] <= 70'(f_s11[i]) * 70'($signed({1'b0, w}));
				pw_s12[i] <= 50'(p_s11[i]) * 50'($signed({1'b0, WeightOne - w}));
			end

			tz_s2 <= (tmax == '0);
			tz_s3 <= tz_s2;
			vsq_s3 <= 64'(rsq_s2[0]) + 64'(rsq_s2[1]) + 64'(rsq_s2[2]);

			root_tx_s[0] <= tsq_s3[0] + tsq_s3[1] + tsq_s3[2];
			root_tres_s[0] <= '0;
			root_vx_s[0] <= vsq_s3;
			root_vres_s[0] <= '0;
			root_tz_s[0] <= tz_s3;

			div_tl_s[0] <= root_tres_s[SqrtSteps][31:0];
			div_kn_s[0] <= 49'((65'(coeff_normal_q) * 65'(vmag)) >> 16);
			div_kt_s[0] <= 49'((65'(coeff_tangent_q) * 65'(vmag)) >> 16);
			div_tz_s[0] <= root_tz_s[SqrtSteps];

			kn_s4 <= div_kn_s[DivSteps];
			kt_s4 <= div_kt_s[DivSteps];
			tz_s4 <= div_tz_s[DivSteps];
			kn_s5 <= kn_s4;
			kt_s5 <= kt_s4;
			tz_s5 <= tz_s4;
			dot_s6 <= 36'(dot_sum >>> UnitFrac);
			kn_s6 <= kn_s5;
			kt_s6 <= kt_s5;
			tz_s6 <= tz_s5;
			kn_s7 <= kn_s6;
			kt_s7 <= kt_s6;
			tz_s7 <= tz_s6;
			kn_s8 <= kn_s7;
			kt_s8 <= kt_s7;
			tz_s8 <= tz_s7;
			sat_s10 <= term_sat;
			sat_s11 <= sat_s10 | f_sat;
			sat_s12 <= sat_s11;

			drag_s13.force_x <= fo[0];
			drag_s13.force_y <= fo[1];
			drag_s13.force_z <= fo[2];
			drag_s13.saturated <= sat_s12 | o_sat;
		end
	end

	// One restoring square-root iteration per stage, both roots side by side.
	for (genvar k = 1; k <= SqrtSteps; k++) begin : g_root
		localparam logic [63:0] RootBit = 64'd1 << (2 * (SqrtSteps - k));
		logic [63:0] t_try, v_try;

		assign t_try = root_tres_s[k-1] + RootBit;
		assign v_try = root_vres_s[k-1] + RootBit;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				root_v_s[k] <= 1'b0;
			end else if (advance) begin
				root_v_s[k] <= root_v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				if (root_tx_s[k-1] >= t_try) begin
					root_tx_s[k] <= root_tx_s[k-1] - t_try;
					root_tres_s[k] <= (root_tres_s[k-1] >> 1) + RootBit;
				end else begin
					root_tx_s[k] <= root_tx_s[k-1];
					root_tres_s[k] <= root_tres_s[k-1] >> 1;
				end
				if (root_vx_s[k-1] >= v_try) begin
					root_vx_s[k] <= root_vx_s[k-1] - v_try;
					root_vres_s[k] <= (root_vres_s[k-1] >> 1) + RootBit;
				end else begin
					root_vx_s[k] <= root_vx_s[k-1];
					root_vres_s[k] <= root_vres_s[k-1] >> 1;
				end
				root_r_s[k] <= root_r_s[k-1];
				root_p_s[k] <= root_p_s[k-1];
				root_tn_s[k] <= root_tn_s[k-1];
				root_tz_s[k] <= root_tz_s[k-1];
			end
		end
	end

	// One quotient bit per stage, most significant first, three lanes.
	for (genvar j = 1; j <= DivSteps; j++) begin : g_div
		localparam int unsigned Sh = DivSteps - j;
		logic [63:0] dvs;

		assign dvs = 64'(div_tl_s[j-1]) << Sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[j] <= 1'b0;
			end else if (advance) begin
				div_v_s[j] <= div_v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				for (int i = 0; i < NumAxes; i++) begin
					if (64'(div_rem_s[j-1][i]) >= dvs) begin
						div_rem_s[j][i] <= 60'(64'(div_rem_s[j-1][i]) - dvs);
						div_q_s[j][i] <= div_q_s[j-1][i] | (29'd1 << Sh);
					end else begin
						div_rem_s[j][i] <= div_rem_s[j-1][i];
						div_q_s[j][i] <= div_q_s[j-1][i];
					end
				end
				div_neg_s[j] <= div_neg_s[j-1];
				div_tl_s[j] <= div_tl_s[j-1];
				div_kn_s[j] <= div_kn_s[j-1];
				div_kt_s[j] <= div_kt_s[j-1];
				div_r_s[j] <= div_r_s[j-1];
				div_p_s[j] <= div_p_s[j-1];
				div_tz_s[j] <= div_tz_s[j-1];
			end
		end
	end

	assign drag_valid = v_s13;
	assign drag = drag_s13;

	`BDFR_ASSERT_ALWAYS(a_stall_holds_input, !(drag_valid && drag_stall) || cell_stall, "output stall did not stall the input")
	`BDFR_ASSERT(a_tangent_length_normalized, !(div_v_s[0] && !div_tz_s[0]) || (div_tl_s[0][31:30] != 2'b00), "tangent length below 2^30 after normalization")
	`BDFR_ASSERT(a_unit_in_range, !(div_v_s[DivSteps] && !div_tz_s[DivSteps]) || (div_q_s[DivSteps][0] <= QuotMax && div_q_s[DivSteps][1] <= QuotMax && div_q_s[DivSteps][2] <= QuotMax), "unit tangent component above one")
	`BDFR_ASSERT(a_zero_tangent_no_axial, !(v_s8 && tz_s8) || (magt_s8[0] == '0 && magt_s8[1] == '0 && magt_s8[2] == '0), "zero tangent produced a tangential part")

endmodule
